// ----- design/two_register_machine_keyed_store_assert.svh -----
// Assertion macros shared by the checker of the two-register machine.
// Each macro expects signals named clock and reset in the enclosing scope.
// No other dependencies.
`ifndef TWO_REGISTER_MACHINE_KEYED_STORE_ASSERT_SVH
`define TWO_REGISTER_MACHINE_KEYED_STORE_ASSERT_SVH

// Check cons in the same cycle whenever ante holds.
`define TRMKS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante holds.
`define TRMKS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/trmks_pkg.sv -----
// Shared types and constants of the two-register machine with keyed store.
// Used by the top level, the divider, the checker. No dependencies.
`default_nettype none

package trmks_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int NAME_CHARS  = 8;
   localparam int KEY_W       = 8 * NAME_CHARS;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Data widths
   localparam int DATA_W      = 32;
   localparam int ENTRY_W     = KEY_W + DATA_W;

   // Stream field widths
   localparam int OP_W        = 3;
   localparam int NAME_W      = 64;
   localparam int STATUS_W    = 2;
   localparam int SLOT_W      = 4;
   localparam int TOTAL_W     = 5;
   localparam int REQ_USED_W  = OP_W + NAME_W + DATA_W + 2;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_USED_W  = STATUS_W + DATA_W + SLOT_W + TOTAL_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   // Divider
   localparam int DIV_STEPS   = DATA_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   typedef enum logic [OP_W-1:0] {
      OP_DECLARE  = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_LOAD     = 3'd2,
      OP_STORE    = 3'd3,
      OP_ADD      = 3'd4,
      OP_SUBTRACT = 3'd5,
      OP_MULTIPLY = 3'd6,
      OP_DIVIDE   = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_DIV_ZERO  = 2'd3
   } status_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- design/trmks_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module trmks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/trmks_div.sv -----
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on trmks_pkg. The caller never starts it with a zero divisor.
`default_nettype none

module trmks_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire trmks_pkg::div_req_type  div_req,
   output trmks_pkg::div_rsp_type       div_rsp
);

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_FIX
   } dstate_type;

   dstate_type                       state_ff, state_in;
   logic [trmks_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [trmks_pkg::DATA_W-1:0]     rem_ff, rem_in;
   logic [trmks_pkg::DATA_W-1:0]     quo_ff, quo_in;
   logic [trmks_pkg::DATA_W-1:0]     dvs_ff, dvs_in;
   logic                             neg_ff, neg_in;
   logic                             done_ff, done_in;
   logic [trmks_pkg::DATA_W-1:0]     quot_ff, quot_in;

   logic [trmks_pkg::DATA_W:0]       rem_sh;
   logic [trmks_pkg::DATA_W:0]       diff;
   logic [trmks_pkg::DATA_W-1:0]     mag_a;
   logic [trmks_pkg::DATA_W-1:0]     mag_b;

   // Magnitudes of the operands; the most negative value maps to 2**31
   assign mag_a = div_req.dividend[trmks_pkg::DATA_W-1] ? -div_req.dividend
                                                        : div_req.dividend;
   assign mag_b = div_req.divisor[trmks_pkg::DATA_W-1] ? -div_req.divisor
                                                       : div_req.divisor;

   // One restoring step
   assign rem_sh = {rem_ff, quo_ff[trmks_pkg::DATA_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               rem_in   = '0;
               quo_in   = mag_a;
               dvs_in   = mag_b;
               neg_in   = div_req.dividend[trmks_pkg::DATA_W-1] ^
                          div_req.divisor[trmks_pkg::DATA_W-1];
               step_in  = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (!diff[trmks_pkg::DATA_W]) begin
               rem_in = diff[trmks_pkg::DATA_W-1:0];
               quo_in = {quo_ff[trmks_pkg::DATA_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[trmks_pkg::DATA_W-1:0];
               quo_in = {quo_ff[trmks_pkg::DATA_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == trmks_pkg::STEP_W'(trmks_pkg::DIV_STEPS - 1)) begin
               state_in = D_FIX;
            end
         end
         D_FIX: begin
            // Apply the sign; the overflow case wraps naturally
            quot_in  = neg_ff ? -quo_ff : quo_ff;
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

`default_nettype wire

// ----- design/two_register_machine_keyed_store.sv -----
// Top level of the two-register machine with a keyed variable store.
// Depends on trmks_pkg, trmks_ram (entry table) and trmks_div (divider).
//
//   channel | dir | signals                      | payload
//   req     | in  | req_tvalid/tready/tdata[103:0] | operation, name_key, value, dest, src
//   rsp     | out | rsp_tvalid/tready/tdata[47:0]  | status, result, slot, entry total
//
// One instruction at a time: declare and add/subtract/multiply go from execute straight to
// the response; divide waits on the divider (one quotient bit a cycle). Remove, load and
// store scan from slot 0, reading and then comparing each entry, and a remove hit then
// moves the last entry into the freed slot.
// Synchronous reset clears registers and the entry count; the table RAM is not cleared.
// A stalled response holds the next instruction in its response state until taken.
`default_nettype none

module two_register_machine_keyed_store (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [2:0] operation, [66:3] name_key, [98:67] value, [99] dest_reg, [100] src_reg
   input  wire logic [trmks_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [1:0] status, [33:2] result_value, [37:34] slot, [42:38] entry_total
   output logic      [trmks_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RD,
      S_CMP,
      S_RMRD,
      S_RMWR,
      S_DIV,
      S_RESP
   } state_type;

   localparam int DW = trmks_pkg::DATA_W;
   localparam int KW = trmks_pkg::KEY_W;
   localparam int CW = trmks_pkg::CNT_W;
   localparam int IW = trmks_pkg::IDX_W;

   state_type                         state_ff, state_in;
   trmks_pkg::op_type                 op_ff, op_in;
   logic [KW-1:0]                     key_ff, key_in;
   logic [DW-1:0]                     val_ff, val_in;
   logic                              dst_ff, dst_in;
   logic                              src_ff, src_in;
   logic [DW-1:0]                     reg_one_ff, reg_one_in;
   logic [DW-1:0]                     reg_two_ff, reg_two_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   trmks_pkg::status_type             status_ff, status_in;
   logic [DW-1:0]                     result_ff, result_in;
   logic [trmks_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [trmks_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                              wr_en;
   logic [IW-1:0]                     wr_addr;
   logic [trmks_pkg::ENTRY_W-1:0]     wr_data;
   logic                              rd_en;
   logic [IW-1:0]                     rd_addr;
   logic [trmks_pkg::ENTRY_W-1:0]     rd_data;
   logic [KW-1:0]                     rd_key;
   logic [DW-1:0]                     rd_val;

   logic [DW-1:0]                     opa;
   logic [DW-1:0]                     opb;
   logic [2*DW-1:0]                   product;
   logic [CW-1:0]                     last_idx;
   logic                              reg_we;
   logic [DW-1:0]                     reg_wv;

   trmks_pkg::div_req_type            div_req;
   trmks_pkg::div_rsp_type            div_rsp;

   // Entry table: {value, name} per slot
   trmks_ram #(
      .WIDTH (trmks_pkg::ENTRY_W),
      .DEPTH (trmks_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   trmks_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rd_key = rd_data[KW-1:0];
   assign rd_val = rd_data[trmks_pkg::ENTRY_W-1:KW];

   // Register operands
   assign opa      = dst_ff ? reg_two_ff : reg_one_ff;
   assign opb      = src_ff ? reg_two_ff : reg_one_ff;
   assign product  = opa * opb;
   assign last_idx = count_ff - 1'b1;

   assign div_req.start    = (state_ff == S_EXEC) && (op_ff == trmks_pkg::OP_DIVIDE) &&
                             (opb != '0);
   assign div_req.dividend = opa;
   assign div_req.divisor  = opb;

   // Next-state and datapath
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      dst_in       = dst_ff;
      src_in       = src_ff;
      reg_one_in   = reg_one_ff;
      reg_two_in   = reg_two_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IW-1:0];
      wr_data      = {opa, rd_key};
      rd_en        = 1'b0;
      rd_addr      = idx_ff[IW-1:0];
      reg_we       = 1'b0;
      reg_wv       = result_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = trmks_pkg::op_type'(req_tdata[2:0]);
               key_in   = req_tdata[3 +: KW];
               val_in   = req_tdata[67 +: DW];
               dst_in   = req_tdata[99];
               src_in   = req_tdata[100];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = trmks_pkg::ST_OK;
            result_in = '0;
            slot_in   = '0;
            idx_in    = '0;
            state_in  = S_RESP;
            unique case (op_ff)
               trmks_pkg::OP_DECLARE: begin
                  if (count_ff == CW'(trmks_pkg::TABLE_DEPTH)) begin
                     status_in = trmks_pkg::ST_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = count_ff[IW-1:0];
                     wr_data   = {val_ff, key_ff};
                     result_in = val_ff;
                     slot_in   = trmks_pkg::SLOT_W'(count_ff);
                     count_in  = count_ff + 1'b1;
                  end
               end
               trmks_pkg::OP_REMOVE,
               trmks_pkg::OP_LOAD,
               trmks_pkg::OP_STORE: begin
                  state_in = S_RD;
               end
               trmks_pkg::OP_ADD: begin
                  result_in = opa + opb;
                  reg_we    = 1'b1;
                  reg_wv    = opa + opb;
               end
               trmks_pkg::OP_SUBTRACT: begin
                  result_in = opa - opb;
                  reg_we    = 1'b1;
                  reg_wv    = opa - opb;
               end
               trmks_pkg::OP_MULTIPLY: begin
                  result_in = product[DW-1:0];
                  reg_we    = 1'b1;
                  reg_wv    = product[DW-1:0];
               end
               trmks_pkg::OP_DIVIDE: begin
                  if (opb == '0) begin
                     status_in = trmks_pkg::ST_DIV_ZERO;
                  end else begin
                     state_in = S_DIV;
                  end
               end
            endcase
         end
         S_RD: begin
            // Issue the read of the next live entry, or give up
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = S_CMP;
            end else begin
               status_in = trmks_pkg::ST_NOT_FOUND;
               state_in  = S_RESP;
            end
         end
         S_CMP: begin
            if (rd_key == key_ff) begin
               slot_in  = trmks_pkg::SLOT_W'(idx_ff);
               state_in = S_RESP;
               priority case (op_ff)
                  trmks_pkg::OP_LOAD: begin
                     result_in = rd_val;
                     reg_we    = 1'b1;
                     reg_wv    = rd_val;
                  end
                  trmks_pkg::OP_STORE: begin
                     result_in = opa;
                     wr_en     = 1'b1;
                  end
                  default: begin
                     state_in = S_RMRD;
                  end
               endcase
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_RMRD: begin
            // Fetch the last entry to fill the freed slot
            rd_en    = 1'b1;
            rd_addr  = last_idx[IW-1:0];
            state_in = S_RMWR;
         end
         S_RMWR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            count_in = last_idx;
            state_in = S_RESP;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               result_in = div_rsp.quotient;
               reg_we    = 1'b1;
               reg_wv    = div_rsp.quotient;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{trmks_pkg::RSP_PAD_W{1'b0}},
                               trmks_pkg::TOTAL_W'(count_ff), slot_ff, result_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
      endcase

      // Register write-back
      if (reg_we) begin
         if (dst_ff) begin
            reg_two_in = reg_wv;
         end else begin
            reg_one_in = reg_wv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reg_one_ff   <= '0;
         reg_two_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reg_one_ff   <= reg_one_in;
         reg_two_ff   <= reg_two_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      dst_ff      <= dst_in;
      src_ff      <= src_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      result_ff   <= result_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/trmks_checker.sv -----
// Port-level checker for the two-register machine, bound to the top level.
// Depends on trmks_pkg and two_register_machine_keyed_store_assert.svh.
`default_nettype none

`include "two_register_machine_keyed_store_assert.svh"

module trmks_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [trmks_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic                              req_fire;
   logic                              rsp_stall;
   logic [1:0]                        rsp_status;
   logic [trmks_pkg::DATA_W-1:0]      rsp_result;
   logic [trmks_pkg::SLOT_W-1:0]      rsp_slot;
   logic [trmks_pkg::TOTAL_W-1:0]     rsp_total;
   logic                              rsp_full;
   logic                              rsp_error;
   logic                              zero_fields;
   logic                              full_total;

   assign req_fire    = req_tvalid && req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_status  = rsp_tdata[1:0];
   assign rsp_result  = rsp_tdata[33:2];
   assign rsp_slot    = rsp_tdata[37:34];
   assign rsp_total   = rsp_tdata[42:38];

   // Classify the response shown on the port
   assign rsp_full    = rsp_tvalid && (rsp_status == trmks_pkg::ST_FULL);
   assign rsp_error   = rsp_tvalid && ((rsp_status == trmks_pkg::ST_NOT_FOUND) ||
                                       (rsp_status == trmks_pkg::ST_DIV_ZERO));
   assign zero_fields = (rsp_result == '0) && (rsp_slot == '0);
   assign full_total  = (rsp_total == trmks_pkg::TOTAL_W'(trmks_pkg::TABLE_DEPTH));

   // One instruction in flight: no request right after an accepted one
   `TRMKS_ASSERT_NEXT(a_one_in_flight, req_fire, !req_tready, "request accepted while busy")

   // Hold a stalled response
   `TRMKS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // Full table reports the full count and no value
   `TRMKS_ASSERT_SAME(a_full_shape, rsp_full, zero_fields && full_total, "table full result malformed")

   // Missing name or zero divisor yield zero value and slot
   `TRMKS_ASSERT_SAME(a_error_zero, rsp_error, zero_fields, "error result not zero")

endmodule

bind two_register_machine_keyed_store trmks_checker u_trmks_checker (.*);

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for two_register_machine_keyed_store: drives instruction
// transactions and checks each response against a built-in machine predictor.
// Depends on trmks_pkg and the top-level RTL only.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          IDLE_LIMIT  = 4000;
   localparam int          DRAIN_PAUSE = 64;
   localparam int          PHASE_ITEMS = 306;
   localparam logic [63:0] KEY_MASK    = (trmks_pkg::KEY_W >= 64) ? '1 :
                                         ((64'd1 << trmks_pkg::KEY_W) - 64'd1);
   localparam logic [63:0] KEY_ZERO    = '0;
   localparam logic [63:0] KEY_ONES    = '1;
   localparam logic [63:0] KEY_MINUS   = "minus";

   typedef struct {
      trmks_pkg::status_type status;
      logic [31:0]           result_value;
      logic [3:0]            slot;
      logic [4:0]            entry_total;
   } result_type;

   // Machine predictor plus the queue of responses it still owes
   class machine_scoreboard;
      logic [31:0]  regs [2];
      logic [63:0]  names [trmks_pkg::TABLE_DEPTH];
      logic [31:0]  values [trmks_pkg::TABLE_DEPTH];
      int unsigned  count;
      result_type   expected_results [$];
      int unsigned  fails;
      int unsigned  checked;
      int unsigned  full_seen;
      int unsigned  missing_seen;
      int unsigned  div_zero_seen;

      function new();
         regs[0] = '0;
         regs[1] = '0;
         for (int i = 0; i < trmks_pkg::TABLE_DEPTH; i++) begin
            names[i]  = '0;
            values[i] = '0;
         end
         count = 0;
         fails = 0;
         checked = 0;
         full_seen = 0;
         missing_seen = 0;
         div_zero_seen = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Advance the machine state by one accepted instruction
      function void note_instr(trmks_pkg::op_type op, logic [63:0] key_in, logic [31:0] val,
                               logic dst, logic src);
         result_type   r;
         logic [63:0]  key;
         logic [31:0]  a;
         logic [31:0]  b;
         int           pos;
         key = key_in & KEY_MASK;
         r.status = trmks_pkg::ST_OK;
         r.result_value = '0;
         r.slot = '0;
         pos = -1;
         case (op)
            trmks_pkg::OP_DECLARE: begin
               if (count >= trmks_pkg::TABLE_DEPTH) begin
                  r.status = trmks_pkg::ST_FULL;
               end else begin
                  names[count]  = key;
                  values[count] = val;
                  r.slot = count[3:0];
                  r.result_value = val;
                  count++;
               end
            end
            trmks_pkg::OP_REMOVE, trmks_pkg::OP_LOAD, trmks_pkg::OP_STORE: begin
               // first match from slot 0 wins
               for (int i = 0; i < count; i++)
                  if (pos < 0 && names[i] == key) pos = i;
               if (pos < 0) begin
                  r.status = trmks_pkg::ST_NOT_FOUND;
               end else begin
                  r.slot = pos[3:0];
                  if (op == trmks_pkg::OP_REMOVE) begin
                     names[pos]  = names[count-1];
                     values[pos] = values[count-1];
                     count--;
                  end else if (op == trmks_pkg::OP_LOAD) begin
                     r.result_value = values[pos];
                     regs[dst] = values[pos];
                  end else begin
                     r.result_value = regs[dst];
                     values[pos] = regs[dst];
                  end
               end
            end
            default: begin
               a = regs[dst];
               b = regs[src];
               case (op)
                  trmks_pkg::OP_ADD:      r.result_value = a + b;
                  trmks_pkg::OP_SUBTRACT: r.result_value = a - b;
                  trmks_pkg::OP_MULTIPLY: r.result_value = a * b;
                  default: begin
                     if (b == 0) r.status = trmks_pkg::ST_DIV_ZERO;
                     else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r.result_value = a;
                     else r.result_value = $signed(a) / $signed(b);
                  end
               endcase
               if (r.status == trmks_pkg::ST_OK) regs[dst] = r.result_value;
            end
         endcase
         r.entry_total = count[4:0];
         if (r.status == trmks_pkg::ST_FULL) full_seen++;
         if (r.status == trmks_pkg::ST_NOT_FOUND) missing_seen++;
         if (r.status == trmks_pkg::ST_DIV_ZERO) div_zero_seen++;
         expected_results.push_back(r);
      endfunction

      // Compare one response transaction with the oldest expectation
      function void check_result(logic [trmks_pkg::RSP_TDATA_W-1:0] bus);
         result_type exp_r;
         if (expected_results.size() == 0) begin
            $error("response with no instruction pending: tdata=%h", bus);
            fails++;
            return;
         end
         exp_r = expected_results.pop_front();
         checked++;
         if (bus[1:0] !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, bus[1:0]);
            fails++;
         end
         if (bus[33:2] !== exp_r.result_value) begin
            $error("result_value: expected %h, actual %h", exp_r.result_value, bus[33:2]);
            fails++;
         end
         if (bus[37:34] !== exp_r.slot) begin
            $error("slot: expected %0d, actual %0d", exp_r.slot, bus[37:34]);
            fails++;
         end
         if (bus[42:38] !== exp_r.entry_total) begin
            $error("entry_total: expected %0d, actual %0d", exp_r.entry_total, bus[42:38]);
            fails++;
         end
      endfunction
   endclass

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // [2:0] operation, [66:3] name_key, [98:67] value, [99] dest_reg, [100] src_reg
   logic [trmks_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // [1:0] status, [33:2] result_value, [37:34] slot, [42:38] entry_total
   logic [trmks_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   machine_scoreboard sb;
   int                send_idle_pct = 6;
   int                recv_idle_pct = 79;
   int unsigned       sent = 0;
   int unsigned       idle_cycles = 0;
   logic [63:0]       key_pool [6];

   two_register_machine_keyed_store u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the response channel at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Check every accepted response transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Offer one instruction, idling first at random, and hold it until accepted
   task automatic send_instr(input trmks_pkg::op_type op, input logic [63:0] key,
                             input logic [31:0] val, input logic dst, input logic src);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, src, dst, val, key, op};
      do @(posedge clock); while (!req_tready);
      sb.note_instr(op, key, val, dst, src);
      sent++;
   endtask

   // Hold off new instructions until every response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(19))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Mostly pooled names so lookups hit, with fresh names as misses
   function automatic logic [63:0] pick_key();
      if ($urandom_range(99) < 15) return {$urandom, $urandom};
      return key_pool[$urandom_range(5)];
   endfunction

   // Random instruction mix that picks, every 40 instructions, between filling and emptying the table
   task automatic run_random(input int items);
      int                pick;
      int                decl_w;
      int                rem_w;
      logic              growing;
      trmks_pkg::op_type op;
      growing = 1'b1;
      for (int n = 0; n < items; n++) begin
         if (n % 40 == 0) growing = $urandom_range(1);
         decl_w = growing ? 35 : 8;
         rem_w  = growing ? 8 : 30;
         pick = $urandom_range(99);
         if (pick < decl_w) op = trmks_pkg::OP_DECLARE;
         else if (pick < decl_w + rem_w) op = trmks_pkg::OP_REMOVE;
         else if (pick < decl_w + rem_w + 18) op = trmks_pkg::OP_LOAD;
         else if (pick < decl_w + rem_w + 30) op = trmks_pkg::OP_STORE;
         else op = trmks_pkg::op_type'(3'd4 + 3'($urandom_range(3)));
         send_instr(op, pick_key(), pick_value(), 1'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      sb = new();
      for (int i = 0; i < 6; i++) key_pool[i] = {$urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: misses on an empty table, extremes, duplicates, divide corner cases
      send_instr(trmks_pkg::OP_DIVIDE,   KEY_ZERO,  32'd0,         1'b0, 1'b0);
      send_instr(trmks_pkg::OP_LOAD,     KEY_ONES,  32'd0,         1'b0, 1'b0);
      send_instr(trmks_pkg::OP_REMOVE,   KEY_ZERO,  32'd0,         1'b0, 1'b0);
      send_instr(trmks_pkg::OP_STORE,    KEY_MINUS, 32'd0,         1'b1, 1'b0);
      send_instr(trmks_pkg::OP_DECLARE,  KEY_ZERO,  32'h8000_0000, 1'b0, 1'b0);
      send_instr(trmks_pkg::OP_DECLARE,  KEY_ONES,  32'h7FFF_FFFF, 1'b1, 1'b1);
      send_instr(trmks_pkg::OP_DECLARE,  KEY_MINUS, 32'hFFFF_FFFF, 1'b0, 1'b1);
      send_instr(trmks_pkg::OP_DECLARE,  KEY_ZERO,  32'd5,         1'b1, 1'b0);
      send_instr(trmks_pkg::OP_LOAD,     KEY_ZERO,  32'd0,         1'b0, 1'b1);
      send_instr(trmks_pkg::OP_LOAD,     KEY_MINUS, 32'd0,         1'b1, 1'b0);
      send_instr(trmks_pkg::OP_DIVIDE,   KEY_ZERO,  32'd0,         1'b0, 1'b1);
      send_instr(trmks_pkg::OP_LOAD,     KEY_ONES,  32'd0,         1'b1, 1'b1);
      send_instr(trmks_pkg::OP_MULTIPLY, KEY_ZERO,  32'd0,         1'b1, 1'b1);
      send_instr(trmks_pkg::OP_ADD,      KEY_ZERO,  32'd0,         1'b0, 1'b1);
      send_instr(trmks_pkg::OP_SUBTRACT, KEY_ZERO,  32'd0,         1'b1, 1'b0);
      send_instr(trmks_pkg::OP_STORE,    KEY_ONES,  32'd0,         1'b1, 1'b0);
      send_instr(trmks_pkg::OP_REMOVE,   KEY_ZERO,  32'd0,         1'b0, 1'b0);
      send_instr(trmks_pkg::OP_LOAD,     KEY_ZERO,  32'd0,         1'b0, 1'b0);
      send_instr(trmks_pkg::OP_DIVIDE,   KEY_ZERO,  32'd0,         1'b0, 1'b1);
      // fill the table, then overflow it once
      while (sb.count < trmks_pkg::TABLE_DEPTH)
         send_instr(trmks_pkg::OP_DECLARE, {$urandom, $urandom}, $urandom, 1'b0, 1'b0);
      send_instr(trmks_pkg::OP_DECLARE, KEY_MINUS, 32'd1, 1'b0, 1'b0);

      // Random phases: sender mostly busy, then receiver mostly busy, then no idling
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 79 : 0;
         recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 6 : 0;
         run_random(PHASE_ITEMS);
         drain();
      end

      repeat (DRAIN_PAUSE) @(posedge clock);
      $display("Ran %0d instructions across three idling phases; %0d responses checked.",
               sent, sb.checked);
      $display("Error statuses predicted: %0d table full, %0d name not found, %0d divide by zero.",
               sb.full_seen, sb.missing_seen, sb.div_zero_seen);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/trmks_pkg.sv
design/trmks_ram.sv
design/trmks_div.sv
design/two_register_machine_keyed_store.sv
design/trmks_checker.sv
verif/tb.sv
